// ===== sv/ntt_pkg.sv =====
// shared constants, codes and command/status types of the ntt engine
`default_nettype none
package ntt_pkg;

    localparam int MAX_POINTS_DEF = 1024;

    localparam logic [29:0] MOD_P    = 30'd998244353;
    localparam logic [29:0] GEN_ROOT = 30'd3;
    localparam logic [63:0] NEG_PINV = 64'd17450252288407896063;
    localparam logic [29:0] R_MOD_P  = 30'd932051910;
    localparam logic [29:0] R2_MOD_P = 30'd299560064;
    localparam logic [29:0] EXP_INV  = MOD_P - 30'd2;
    localparam logic [29:0] P_MINUS1 = MOD_P - 30'd1;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_RUN   = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // operand sources
    localparam logic [3:0] OP_U    = 4'd0;
    localparam logic [3:0] OP_V    = 4'd1;
    localparam logic [3:0] OP_W    = 4'd2;
    localparam logic [3:0] OP_WL   = 4'd3;
    localparam logic [3:0] OP_ACC  = 4'd4;
    localparam logic [3:0] OP_B    = 4'd5;
    localparam logic [3:0] OP_ROOT = 4'd6;
    localparam logic [3:0] OP_RD   = 4'd7;
    localparam logic [3:0] OP_ONE  = 4'd8;
    localparam logic [3:0] OP_R2   = 4'd9;
    localparam logic [3:0] OP_GEN  = 4'd10;
    localparam logic [3:0] OP_N    = 4'd11;

    // destination registers
    localparam logic [2:0] RG_U    = 3'd0;
    localparam logic [2:0] RG_V    = 3'd1;
    localparam logic [2:0] RG_W    = 3'd2;
    localparam logic [2:0] RG_WL   = 3'd3;
    localparam logic [2:0] RG_ACC  = 3'd4;
    localparam logic [2:0] RG_B    = 3'd5;
    localparam logic [2:0] RG_ROOT = 3'd6;

    // memory write data sources
    localparam logic [2:0] WS_IN   = 3'd0;
    localparam logic [2:0] WS_ZERO = 3'd1;
    localparam logic [2:0] WS_RD   = 3'd2;
    localparam logic [2:0] WS_U    = 3'd3;
    localparam logic [2:0] WS_V    = 3'd4;
    localparam logic [2:0] WS_SUM  = 3'd5;
    localparam logic [2:0] WS_DIFF = 3'd6;

    typedef struct packed {
        logic        mv_en;
        logic [2:0]  mv_dst;
        logic [3:0]  mv_src;
        logic        acc_init;
        logic        mul_start;
        logic [3:0]  mul_a;
        logic [3:0]  mul_b;
        logic [2:0]  mul_dst;
        logic        ram_re;
        logic        ram_we;
        logic [2:0]  ram_wsel;
        logic        out_ld;
        logic        out_run;
        logic [29:0] n_val;
    } t_cmd;

    typedef struct packed {
        logic mul_busy;
        logic mul_done;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// ===== sv/ntt_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none
module ntt_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== sv/ntt_mont.sv =====
// iterative montgomery multiplier, r = 2^64, one shared 32x32 multiplier
`default_nettype none
module ntt_mont (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [29:0] i_a,
    input  wire logic [29:0] i_b,
    output logic             o_busy,
    output logic             o_done,
    output logic      [29:0] o_res
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_Q1   = 3'd2;
    localparam logic [2:0] S_R1   = 3'd3;
    localparam logic [2:0] S_Q2   = 3'd4;
    localparam logic [2:0] S_R2   = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    localparam logic [31:0] PINV32 = ntt_pkg::NEG_PINV[31:0];

    logic [2:0]  r_step;
    logic [2:0]  n_step;
    logic [29:0] r_a;
    logic [29:0] r_b;
    logic [59:0] r_t;
    logic [31:0] r_q;
    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] prod;
    logic [63:0] red_sum;

    always_comb begin
        mul_x = {2'b00, r_a};
        mul_y = {2'b00, r_b};
        n_step = r_step;
        case (r_step)
            S_IDLE: begin
                if (i_start) begin
                    n_step = S_MUL;
                end
            end
            S_MUL: n_step = S_Q1;
            S_Q1: begin
                mul_x  = r_t[31:0];
                mul_y  = PINV32;
                n_step = S_R1;
            end
            S_R1: begin
                mul_x  = r_q;
                mul_y  = {2'b00, ntt_pkg::MOD_P};
                n_step = S_Q2;
            end
            S_Q2: begin
                mul_x  = r_t[31:0];
                mul_y  = PINV32;
                n_step = S_R2;
            end
            S_R2: begin
                mul_x  = r_q;
                mul_y  = {2'b00, ntt_pkg::MOD_P};
                n_step = S_FIN;
            end
            S_FIN: n_step = S_IDLE;
            default: n_step = S_IDLE;
        endcase
    end

    assign prod    = mul_x * mul_y;
    assign red_sum = {4'b0000, r_t} + prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_step)
            S_IDLE: begin
                if (i_start) begin
                    r_a <= i_a;
                    r_b <= i_b;
                end
            end
            S_MUL: r_t <= prod[59:0];
            S_Q1:  r_q <= prod[31:0];
            S_R1:  r_t <= {28'd0, red_sum[63:32]};
            S_Q2:  r_q <= prod[31:0];
            S_R2:  r_t <= {28'd0, red_sum[63:32]};
            default: ;
        endcase
    end

    assign o_busy = (r_step != S_IDLE);
    assign o_done = (r_step == S_FIN);
    assign o_res  = (r_t >= {30'd0, ntt_pkg::MOD_P}) ? 30'(r_t - {30'd0, ntt_pkg::MOD_P})
                                                     : r_t[29:0];

endmodule
`default_nettype wire

// ===== sv/ntt_dp.sv =====
// ntt datapath: coefficient ram, montgomery unit, value registers, result register
`default_nettype none
module ntt_dp #(
    parameter int MAX_POINTS = ntt_pkg::MAX_POINTS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire ntt_pkg::t_cmd                 i_cmd,
    input  wire logic [$clog2(MAX_POINTS)-1:0] i_raddr,
    input  wire logic [$clog2(MAX_POINTS)-1:0] i_waddr,
    input  wire logic [29:0]                   i_coeff_value,
    input  wire logic                          i_out_ready,
    output ntt_pkg::t_sts                      o_sts,
    output logic                               o_out_valid,
    output logic      [29:0]                   o_read_value,
    output logic                               o_transform_done
);

    logic [29:0] r_u;
    logic [29:0] r_v;
    logic [29:0] r_w;
    logic [29:0] r_wl;
    logic [29:0] r_acc;
    logic [29:0] r_b;
    logic [29:0] r_root;
    logic [2:0]  r_dst;
    logic [29:0] rdata;
    logic [29:0] wdata;
    logic [29:0] mv_val;
    logic [29:0] mul_a;
    logic [29:0] mul_b;
    logic [29:0] mul_res;
    logic        mul_busy;
    logic        mul_done;
    logic [29:0] in_red;
    logic [30:0] sum_raw;
    logic [30:0] diff_raw;
    logic [29:0] sum_red;
    logic [29:0] diff_red;

    function automatic logic [29:0] op_sel(
        input logic [3:0]  code,
        input logic [29:0] u,
        input logic [29:0] v,
        input logic [29:0] w,
        input logic [29:0] wl,
        input logic [29:0] acc,
        input logic [29:0] b,
        input logic [29:0] root,
        input logic [29:0] rd,
        input logic [29:0] nv
    );
        logic [29:0] val;
        case (code)
            ntt_pkg::OP_U:    val = u;
            ntt_pkg::OP_V:    val = v;
            ntt_pkg::OP_W:    val = w;
            ntt_pkg::OP_WL:   val = wl;
            ntt_pkg::OP_ACC:  val = acc;
            ntt_pkg::OP_B:    val = b;
            ntt_pkg::OP_ROOT: val = root;
            ntt_pkg::OP_RD:   val = rd;
            ntt_pkg::OP_ONE:  val = ntt_pkg::R_MOD_P;
            ntt_pkg::OP_R2:   val = ntt_pkg::R2_MOD_P;
            ntt_pkg::OP_GEN:  val = ntt_pkg::GEN_ROOT;
            ntt_pkg::OP_N:    val = nv;
            default:          val = 30'd0;
        endcase
        return val;
    endfunction

    assign mv_val = op_sel(i_cmd.mv_src, r_u, r_v, r_w, r_wl, r_acc, r_b, r_root, rdata,
                           i_cmd.n_val);
    assign mul_a  = op_sel(i_cmd.mul_a, r_u, r_v, r_w, r_wl, r_acc, r_b, r_root, rdata,
                           i_cmd.n_val);
    assign mul_b  = op_sel(i_cmd.mul_b, r_u, r_v, r_w, r_wl, r_acc, r_b, r_root, rdata,
                           i_cmd.n_val);

    ntt_mont u_mont (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_busy  (mul_busy),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    // input reduction, butterfly add and subtract mod p
    assign in_red   = (i_coeff_value >= ntt_pkg::MOD_P) ? i_coeff_value - ntt_pkg::MOD_P
                                                        : i_coeff_value;
    assign sum_raw  = {1'b0, r_u} + {1'b0, r_v};
    assign diff_raw = {1'b0, r_u} + {1'b0, ntt_pkg::MOD_P} - {1'b0, r_v};
    assign sum_red  = (sum_raw >= {1'b0, ntt_pkg::MOD_P})
                    ? 30'(sum_raw - {1'b0, ntt_pkg::MOD_P}) : sum_raw[29:0];
    assign diff_red = (diff_raw >= {1'b0, ntt_pkg::MOD_P})
                    ? 30'(diff_raw - {1'b0, ntt_pkg::MOD_P}) : diff_raw[29:0];

    always_comb begin
        case (i_cmd.ram_wsel)
            ntt_pkg::WS_IN:   wdata = in_red;
            ntt_pkg::WS_ZERO: wdata = 30'd0;
            ntt_pkg::WS_RD:   wdata = rdata;
            ntt_pkg::WS_U:    wdata = r_u;
            ntt_pkg::WS_V:    wdata = r_v;
            ntt_pkg::WS_SUM:  wdata = sum_red;
            ntt_pkg::WS_DIFF: wdata = diff_red;
            default:          wdata = 30'd0;
        endcase
    end

    ntt_ram #(
        .WIDTH (30),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_we),
        .i_waddr (i_waddr),
        .i_wdata (wdata),
        .i_re    (i_cmd.ram_re),
        .i_raddr (i_raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.mv_en) begin
            case (i_cmd.mv_dst)
                ntt_pkg::RG_U:    r_u    <= mv_val;
                ntt_pkg::RG_V:    r_v    <= mv_val;
                ntt_pkg::RG_W:    r_w    <= mv_val;
                ntt_pkg::RG_WL:   r_wl   <= mv_val;
                ntt_pkg::RG_ACC:  r_acc  <= mv_val;
                ntt_pkg::RG_B:    r_b    <= mv_val;
                ntt_pkg::RG_ROOT: r_root <= mv_val;
                default: ;
            endcase
        end
        if (mul_done) begin
            case (r_dst)
                ntt_pkg::RG_U:    r_u    <= mul_res;
                ntt_pkg::RG_V:    r_v    <= mul_res;
                ntt_pkg::RG_W:    r_w    <= mul_res;
                ntt_pkg::RG_WL:   r_wl   <= mul_res;
                ntt_pkg::RG_ACC:  r_acc  <= mul_res;
                ntt_pkg::RG_B:    r_b    <= mul_res;
                ntt_pkg::RG_ROOT: r_root <= mul_res;
                default: ;
            endcase
        end
        if (i_cmd.acc_init) begin
            r_acc <= ntt_pkg::R_MOD_P;
        end
        if (i_cmd.mul_start) begin
            r_dst <= i_cmd.mul_dst;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            o_read_value     <= i_cmd.out_run ? 30'd0 : rdata;
            o_transform_done <= i_cmd.out_run;
        end
    end

    assign o_sts.mul_busy = mul_busy;
    assign o_sts.mul_done = mul_done;
    assign o_sts.out_free = !o_out_valid || i_out_ready;

endmodule
`default_nettype wire

// ===== sv/ntt_ctrl.sv =====
// ntt controller: request decode, clear pass, bit reversal, stage, power and scaling loops
`default_nettype none
module ntt_ctrl #(
    parameter int MAX_POINTS = ntt_pkg::MAX_POINTS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [1:0]                    i_kind,
    input  wire logic [9:0]                    i_coeff_index,
    input  wire logic [3:0]                    i_size_log2,
    input  wire logic                          i_inverse,
    input  wire ntt_pkg::t_sts                 i_sts,
    output ntt_pkg::t_cmd                      o_cmd,
    output logic      [$clog2(MAX_POINTS)-1:0] o_raddr,
    output logic      [$clog2(MAX_POINTS)-1:0] o_waddr
);

    localparam int AW = $clog2(MAX_POINTS);

    localparam logic [5:0] ST_CLR      = 6'd0;
    localparam logic [5:0] ST_IDLE     = 6'd1;
    localparam logic [5:0] ST_RD_OUT   = 6'd2;
    localparam logic [5:0] ST_ROOT     = 6'd3;
    localparam logic [5:0] ST_ROOT_W   = 6'd4;
    localparam logic [5:0] ST_BR       = 6'd5;
    localparam logic [5:0] ST_BR_RJ    = 6'd6;
    localparam logic [5:0] ST_BR_WI    = 6'd7;
    localparam logic [5:0] ST_BR_WJ    = 6'd8;
    localparam logic [5:0] ST_STG      = 6'd9;
    localparam logic [5:0] ST_POW      = 6'd10;
    localparam logic [5:0] ST_POW_W1   = 6'd11;
    localparam logic [5:0] ST_POW_SQ   = 6'd12;
    localparam logic [5:0] ST_POW_W2   = 6'd13;
    localparam logic [5:0] ST_STG_INV  = 6'd14;
    localparam logic [5:0] ST_STG_INV2 = 6'd15;
    localparam logic [5:0] ST_STG_INV3 = 6'd16;
    localparam logic [5:0] ST_BF_INIT  = 6'd17;
    localparam logic [5:0] ST_BF_RH    = 6'd18;
    localparam logic [5:0] ST_BF_RL    = 6'd19;
    localparam logic [5:0] ST_BF_RLW   = 6'd20;
    localparam logic [5:0] ST_BF_MW    = 6'd21;
    localparam logic [5:0] ST_BF_WL    = 6'd22;
    localparam logic [5:0] ST_BF_WH    = 6'd23;
    localparam logic [5:0] ST_BF_WW    = 6'd24;
    localparam logic [5:0] ST_SCL      = 6'd25;
    localparam logic [5:0] ST_SCL_W    = 6'd26;
    localparam logic [5:0] ST_SC_R     = 6'd27;
    localparam logic [5:0] ST_SC_M     = 6'd28;
    localparam logic [5:0] ST_SC_W     = 6'd29;
    localparam logic [5:0] ST_SC_WR    = 6'd30;
    localparam logic [5:0] ST_DONE     = 6'd31;

    logic [5:0]    r_state;
    logic [5:0]    n_state;
    logic [5:0]    r_ret;
    logic [5:0]    n_ret;
    logic [AW:0]   r_i;
    logic [AW:0]   n_i;
    logic [AW-1:0] r_k;
    logic [AW-1:0] n_k;
    logic [AW:0]   r_blk;
    logic [AW:0]   n_blk;
    logic [4:0]    r_s;
    logic [4:0]    n_s;
    logic [29:0]   r_e;
    logic [29:0]   n_e;

    logic [4:0]    logn;
    logic [AW:0]   n_pts;
    logic [AW:0]   len;
    logic [AW:0]   half;
    logic [AW-1:0] lo;
    logic [AW-1:0] hi;
    logic [AW-1:0] rev;
    logic [AW-1:0] j_idx;
    logic [AW+9:0] idx_ext;
    logic [AW-1:0] idx;
    logic [29:0]   e_stage;

    assign logn    = ({1'b0, i_size_log2} > 5'(AW)) ? 5'(AW) : {1'b0, i_size_log2};
    assign n_pts   = (AW+1)'(1) << logn;
    assign len     = (AW+1)'(1) << r_s;
    assign half    = len >> 1;
    assign lo      = r_blk[AW-1:0] + r_k;
    assign hi      = lo + half[AW-1:0];
    assign idx_ext = (AW+10)'(i_coeff_index);
    assign idx     = idx_ext[AW-1:0];
    assign e_stage = ntt_pkg::P_MINUS1 >> r_s;

    always_comb begin
        for (int b = 0; b < AW; b++) begin
            rev[b] = r_i[AW-1-b];
        end
    end
    assign j_idx = rev >> (5'(AW) - logn);

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_i        = r_i;
        n_k        = r_k;
        n_blk      = r_blk;
        n_s        = r_s;
        n_e        = r_e;
        o_cmd      = '0;
        o_cmd.n_val = 30'(n_pts);
        o_raddr    = r_i[AW-1:0];
        o_waddr    = r_i[AW-1:0];
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLR: begin
                o_cmd.ram_we   = 1'b1;
                o_cmd.ram_wsel = ntt_pkg::WS_ZERO;
                if (r_i[AW-1:0] == {AW{1'b1}}) begin
                    n_i     = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_raddr    = idx;
                o_waddr    = idx;
                if (i_in_valid) begin
                    case (i_kind)
                        ntt_pkg::KIND_WRITE: begin
                            o_cmd.ram_we   = 1'b1;
                            o_cmd.ram_wsel = ntt_pkg::WS_IN;
                        end
                        ntt_pkg::KIND_READ: begin
                            o_cmd.ram_re = 1'b1;
                            n_state      = ST_RD_OUT;
                        end
                        ntt_pkg::KIND_RUN: n_state = ST_ROOT;
                        default: ;
                    endcase
                end
            end
            ST_RD_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_ROOT: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_a     = ntt_pkg::OP_GEN;
                o_cmd.mul_b     = ntt_pkg::OP_R2;
                o_cmd.mul_dst   = ntt_pkg::RG_ROOT;
                n_state         = ST_ROOT_W;
            end
            ST_ROOT_W: begin
                if (i_sts.mul_done) begin
                    n_i     = (AW+1)'(1);
                    n_state = ST_BR;
                end
            end
            ST_BR: begin
                if (r_i >= n_pts) begin
                    n_s     = 5'd1;
                    n_state = ST_STG;
                end else if (r_i < {1'b0, j_idx}) begin
                    o_cmd.ram_re = 1'b1;
                    n_state      = ST_BR_RJ;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            ST_BR_RJ: begin
                o_cmd.mv_en  = 1'b1;
                o_cmd.mv_dst = ntt_pkg::RG_U;
                o_cmd.mv_src = ntt_pkg::OP_RD;
                o_cmd.ram_re = 1'b1;
                o_raddr      = j_idx;
                n_state      = ST_BR_WI;
            end
            ST_BR_WI: begin
                o_cmd.ram_we   = 1'b1;
                o_cmd.ram_wsel = ntt_pkg::WS_RD;
                n_state        = ST_BR_WJ;
            end
            ST_BR_WJ: begin
                o_cmd.ram_we   = 1'b1;
                o_cmd.ram_wsel = ntt_pkg::WS_U;
                o_waddr        = j_idx;
                n_i            = r_i + 1'b1;
                n_state        = ST_BR;
            end
            ST_STG: begin
                if (r_s > logn) begin
                    n_state = ST_SCL;
                end else begin
                    o_cmd.mv_en    = 1'b1;
                    o_cmd.mv_dst   = ntt_pkg::RG_B;
                    o_cmd.mv_src   = ntt_pkg::OP_ROOT;
                    o_cmd.acc_init = 1'b1;
                    n_e            = e_stage;
                    n_ret          = ST_STG_INV;
                    n_state        = ST_POW;
                end
            end
            ST_POW: begin
                if (r_e == 30'd0) begin
                    n_state = r_ret;
                end else if (r_e[0]) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_a     = ntt_pkg::OP_ACC;
                    o_cmd.mul_b     = ntt_pkg::OP_B;
                    o_cmd.mul_dst   = ntt_pkg::RG_ACC;
                    n_state         = ST_POW_W1;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_a     = ntt_pkg::OP_B;
                    o_cmd.mul_b     = ntt_pkg::OP_B;
                    o_cmd.mul_dst   = ntt_pkg::RG_B;
                    n_state         = ST_POW_W2;
                end
            end
            ST_POW_W1: begin
                if (i_sts.mul_done) begin
                    n_state = ST_POW_SQ;
                end
            end
            ST_POW_SQ: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_a     = ntt_pkg::OP_B;
                o_cmd.mul_b     = ntt_pkg::OP_B;
                o_cmd.mul_dst   = ntt_pkg::RG_B;
                n_state         = ST_POW_W2;
            end
            ST_POW_W2: begin
                if (i_sts.mul_done) begin
                    n_e     = r_e >> 1;
                    n_state = ST_POW;
                end
            end
            ST_STG_INV: begin
                o_cmd.mv_en  = 1'b1;
                o_cmd.mv_dst = ntt_pkg::RG_WL;
                o_cmd.mv_src = ntt_pkg::OP_ACC;
                n_state      = ST_STG_INV2;
            end
            ST_STG_INV2: begin
                if (i_inverse) begin
                    o_cmd.mv_en    = 1'b1;
                    o_cmd.mv_dst   = ntt_pkg::RG_B;
                    o_cmd.mv_src   = ntt_pkg::OP_WL;
                    o_cmd.acc_init = 1'b1;
                    n_e            = ntt_pkg::EXP_INV;
                    n_ret          = ST_STG_INV3;
                    n_state        = ST_POW;
                end else begin
                    n_state = ST_BF_INIT;
                end
            end
            ST_STG_INV3: begin
                o_cmd.mv_en  = 1'b1;
                o_cmd.mv_dst = ntt_pkg::RG_WL;
                o_cmd.mv_src = ntt_pkg::OP_ACC;
                n_state      = ST_BF_INIT;
            end
            ST_BF_INIT: begin
                o_cmd.mv_en  = 1'b1;
                o_cmd.mv_dst = ntt_pkg::RG_W;
                o_cmd.mv_src = ntt_pkg::OP_ONE;
                n_k          = '0;
                n_blk        = '0;
                n_state      = ST_BF_RH;
            end
            ST_BF_RH: begin
                o_cmd.ram_re = 1'b1;
                o_raddr      = hi;
                n_state      = ST_BF_RL;
            end
            ST_BF_RL: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_a     = ntt_pkg::OP_RD;
                o_cmd.mul_b     = ntt_pkg::OP_W;
                o_cmd.mul_dst   = ntt_pkg::RG_V;
                o_cmd.ram_re    = 1'b1;
                o_raddr         = lo;
                n_state         = ST_BF_RLW;
            end
            ST_BF_RLW: begin
                o_cmd.mv_en  = 1'b1;
                o_cmd.mv_dst = ntt_pkg::RG_U;
                o_cmd.mv_src = ntt_pkg::OP_RD;
                n_state      = ST_BF_MW;
            end
            ST_BF_MW: begin
                if (i_sts.mul_done) begin
                    n_state = ST_BF_WL;
                end
            end
            ST_BF_WL: begin
                o_cmd.ram_we   = 1'b1;
                o_cmd.ram_wsel = ntt_pkg::WS_SUM;
                o_waddr        = lo;
                n_state        = ST_BF_WH;
            end
            ST_BF_WH: begin
                o_cmd.ram_we   = 1'b1;
                o_cmd.ram_wsel = ntt_pkg::WS_DIFF;
                o_waddr        = hi;
                if ((r_blk + len) == n_pts) begin
                    n_blk = '0;
                    if (({1'b0, r_k} + (AW+1)'(1)) == half) begin
                        n_s     = r_s + 5'd1;
                        n_state = ST_STG;
                    end else begin
                        n_k             = r_k + 1'b1;
                        o_cmd.mul_start = 1'b1;
                        o_cmd.mul_a     = ntt_pkg::OP_W;
                        o_cmd.mul_b     = ntt_pkg::OP_WL;
                        o_cmd.mul_dst   = ntt_pkg::RG_W;
                        n_state         = ST_BF_WW;
                    end
                end else begin
                    n_blk   = r_blk + len;
                    n_state = ST_BF_RH;
                end
            end
            ST_BF_WW: begin
                if (i_sts.mul_done) begin
                    n_state = ST_BF_RH;
                end
            end
            ST_SCL: begin
                if (i_inverse) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_a     = ntt_pkg::OP_N;
                    o_cmd.mul_b     = ntt_pkg::OP_R2;
                    o_cmd.mul_dst   = ntt_pkg::RG_B;
                    n_state         = ST_SCL_W;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SCL_W: begin
                if (i_sts.mul_done) begin
                    o_cmd.acc_init = 1'b1;
                    n_e            = ntt_pkg::EXP_INV;
                    n_ret          = ST_SC_R;
                    n_i            = '0;
                    n_state        = ST_POW;
                end
            end
            ST_SC_R: begin
                o_cmd.ram_re = 1'b1;
                n_state      = ST_SC_M;
            end
            ST_SC_M: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_a     = ntt_pkg::OP_RD;
                o_cmd.mul_b     = ntt_pkg::OP_ACC;
                o_cmd.mul_dst   = ntt_pkg::RG_V;
                n_state         = ST_SC_W;
            end
            ST_SC_W: begin
                if (i_sts.mul_done) begin
                    n_state = ST_SC_WR;
                end
            end
            ST_SC_WR: begin
                o_cmd.ram_we   = 1'b1;
                o_cmd.ram_wsel = ntt_pkg::WS_V;
                if ((r_i + 1'b1) == n_pts) begin
                    n_state = ST_DONE;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = ST_SC_R;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld  = 1'b1;
                    o_cmd.out_run = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_ret   <= ST_IDLE;
            r_i     <= '0;
            r_k     <= '0;
            r_blk   <= '0;
            r_s     <= '0;
            r_e     <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_i     <= n_i;
            r_k     <= n_k;
            r_blk   <= n_blk;
            r_s     <= n_s;
            r_e     <= n_e;
        end
    end

endmodule
`default_nettype wire

// ===== sv/ntt_montgomery_engine.sv =====
// ntt engine top level: configuration registers, controller and datapath
//
// requests come in on the input channel (valid/ready) and are taken one at
// a time. a write request stores a coefficient and gives no result. a read
// request reads the ram, then loads its result register once that is free.
// a run request transforms the first n = 2^size_log2 entries (size_log2
// capped at log2(MAX_POINTS)) in place and returns one result with
// transform_done set. a run takes (n/2)*log2(n) butterflies plus the twiddle
// steps, the bit-reversal swaps, up to 60 products per stage for the twiddle
// power (twice that in inverse mode), and in inverse mode a power for 1/n
// and a scaling of every entry; all products share the single iterative
// montgomery unit.
// results sit in an output register; while it waits, write requests are
// still taken, a read or run request is taken but holds the input channel
// until the register is free.
// after reset the coefficient ram is zeroed, one entry a cycle, all entries,
// with the input channel not ready. configuration goes over the apb
// port, size_log2 at address 0 and inverse_transform at address 4.
`default_nettype none
module ntt_montgomery_engine #(
    parameter int MAX_POINTS = ntt_pkg::MAX_POINTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_kind,
    input  wire logic [9:0]  i_coeff_index,
    input  wire logic [29:0] i_coeff_value,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic      [29:0] o_read_value,
    output logic             o_transform_done,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam logic REG_SIZE = 1'b0;
    localparam logic REG_INV  = 1'b1;

    logic [3:0]    r_size_log2;
    logic          r_inverse;
    ntt_pkg::t_cmd w_cmd;
    ntt_pkg::t_sts w_sts;
    logic [AW-1:0] w_raddr;
    logic [AW-1:0] w_waddr;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_log2 <= 4'd10;
            r_inverse   <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_SIZE: r_size_log2 <= pwdata[3:0];
                REG_INV:  r_inverse   <= pwdata[0];
                default: ;
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_INV) ? {31'd0, r_inverse} : {28'd0, r_size_log2};

    ntt_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_coeff_index (i_coeff_index),
        .i_size_log2   (r_size_log2),
        .i_inverse     (r_inverse),
        .i_sts         (w_sts),
        .o_cmd         (w_cmd),
        .o_raddr       (w_raddr),
        .o_waddr       (w_waddr)
    );

    ntt_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_raddr          (w_raddr),
        .i_waddr          (w_waddr),
        .i_coeff_value    (i_coeff_value),
        .i_out_ready      (i_out_ready),
        .o_sts            (w_sts),
        .o_out_valid      (o_out_valid),
        .o_read_value     (o_read_value),
        .o_transform_done (o_transform_done)
    );

    a_mul_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.mul_start |-> !w_sts.mul_busy)
        else $error("multiply started while unit busy");

    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_ld |-> w_sts.out_free)
        else $error("result register overwritten");

    a_ready_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_sts.mul_busy)
        else $error("ready while a product is in flight");

    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_transform_done) |-> (o_read_value == 30'd0))
        else $error("run result carries read data");

endmodule
`default_nettype wire
